### hw/rtl/ctw_pkg.sv
`timescale 1ns / 1ps

package ctw_pkg;

	// Field widths of the command and response beats.
	localparam int OP_W   = 3;
	localparam int BYTE_W = 8;
	localparam int COLX_W = 7;
	localparam int ROWY_W = 5;
	localparam int ROWO_W = 5;
	localparam int CELL_W = 16;

	// Operation codes carried in the op field.
	typedef enum logic [OP_W-1:0] {
		OP_PUT   = 3'd0,
		OP_CLEAR = 3'd1,
		OP_LEFT  = 3'd2,
		OP_RIGHT = 3'd3,
		OP_UP    = 3'd4,
		OP_DOWN  = 3'd5,
		OP_PLACE = 3'd6,
		OP_READ  = 3'd7
	} op_t;

	// Special characters and fill values.
	localparam logic [BYTE_W-1:0] CH_NUL      = 8'h00;
	localparam logic [BYTE_W-1:0] CH_TAB      = 8'h09;
	localparam logic [BYTE_W-1:0] CH_NL       = 8'h0a;
	localparam logic [BYTE_W-1:0] CH_ESC      = 8'h1b;
	localparam logic [BYTE_W-1:0] CH_SPACE    = 8'h20;
	localparam logic [BYTE_W-1:0] RESET_COLOR = 8'h07;
	localparam logic [CELL_W-1:0] BLANK_FILL  = 16'h0f00;

	// One classified command held in the queue between front and back.
	typedef struct packed {
		op_t                 op;
		logic [BYTE_W-1:0]   ch;
		logic [COLX_W-1:0]   x;
		logic [ROWY_W-1:0]   y;
		logic                pos_ok;
	} q_entry_t;

endpackage

### hw/rtl/ctw_ifs.sv
`timescale 1ns / 1ps

interface ctw_cmd_if;
	import ctw_pkg::*;
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     op;
	logic [BYTE_W-1:0]   char_byte;
	logic [COLX_W-1:0]   col_x;
	logic [ROWY_W-1:0]   row_y;

	modport source (output valid, op, char_byte, col_x, row_y, input ready);
	modport sink (input valid, op, char_byte, col_x, row_y, output ready);
endinterface

interface ctw_rsp_if;
	import ctw_pkg::*;
	logic                valid;
	logic                ready;
	logic [ROWO_W-1:0]   cursor_row;
	logic [COLX_W-1:0]   cursor_col;
	logic [BYTE_W-1:0]   text_color;
	logic [CELL_W-1:0]   read_data;
	logic                bad_position;

	modport source (output valid, cursor_row, cursor_col, text_color, read_data,
		bad_position, input ready);
	modport sink (input valid, cursor_row, cursor_col, text_color, read_data,
		bad_position, output ready);
endinterface

### hw/rtl/ctw_ram.sv
`timescale 1ns / 1ps

module ctw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hw/rtl/ctw_front.sv
`timescale 1ns / 1ps

module ctw_front #(
	parameter int COLS = 80,
	parameter int ROWS = 25
) (
	input  logic              clk,
	input  logic              arst_n,
	ctw_cmd_if.sink           cmd,
	input  logic              init_busy,
	output logic              q_valid,
	input  logic              q_ready,
	output ctw_pkg::q_entry_t q_entry
);
	import ctw_pkg::*;

	q_entry_t   ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;
	q_entry_t   cls;

	// Classify the incoming beat: check the position against the screen.
	always_comb begin
		cls.op     = op_t'(cmd.op);
		cls.ch     = cmd.char_byte;
		cls.x      = cmd.col_x;
		cls.y      = cmd.row_y;
		cls.pos_ok = (int'(cmd.col_x) < COLS) && (int'(cmd.row_y) < ROWS);
	end

	// No beat is taken while the cell store is being cleared after reset.
	assign cmd.ready = (count_q != 2'd2) && !init_busy;
	assign push      = cmd.valid && cmd.ready;
	assign q_valid   = (count_q != 2'd0);
	assign pop       = q_valid && q_ready;
	assign q_entry   = ent_q[rd_ptr_q];

	// Two-entry queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= cls;
		end
	end

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

### hw/rtl/ctw_back.sv
`timescale 1ns / 1ps

module ctw_back #(
	parameter int COLS      = 80,
	parameter int ROWS      = 25,
	parameter int TAB_WIDTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	output logic              q_ready,
	input  ctw_pkg::q_entry_t q_entry,
	output logic              init_busy,
	ctw_rsp_if.source         rsp
);
	import ctw_pkg::*;

	localparam int CELLS = ROWS * COLS;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(COLS);
	localparam int RW    = $clog2(ROWS + 1);
	localparam int TW    = $clog2(TAB_WIDTH + 1);

	typedef enum logic [5:0] {
		ST_CLR   = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_SCR   = 6'b000100,
		ST_FILL  = 6'b001000,
		ST_WCELL = 6'b010000,
		ST_RDW   = 6'b100000
	} state_t;

	state_t            state_q, state_d;
	logic [RW-1:0]     row_q, row_d;
	logic [CW-1:0]     col_q, col_d;
	logic [BYTE_W-1:0] color_q, color_d;
	logic              esc_q, esc_d;
	logic [AW-1:0]     cnt_q, cnt_d;
	logic [TW-1:0]     tab_q, tab_d;
	logic [BYTE_W-1:0] ch_q, ch_d;
	logic              ret_q, ret_d;
	logic              init_q, init_d;
	logic              pend_s1, pend_d;
	logic [AW-1:0]     waddr_s1;
	logic              out_valid_q;
	logic [CELL_W-1:0] out_rd_q;
	logic              out_bad_q;
	logic [RW-1:0]     out_row_q;
	logic [CW-1:0]     out_col_q;
	logic [BYTE_W-1:0] out_color_q;

	logic              fin;
	logic [CELL_W-1:0] fin_rd;
	logic              fin_bad;
	logic              slot_free;
	logic              full;
	logic [AW-1:0]     cur_addr;
	logic [AW-1:0]     ent_addr;

	logic              we;
	logic [AW-1:0]     waddr;
	logic [CELL_W-1:0] wdata;
	logic [AW-1:0]     raddr;
	logic [CELL_W-1:0] rdata;

	ctw_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_cells (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign full      = (row_q == RW'(ROWS));
	assign cur_addr  = AW'(AW'(row_q) * AW'(COLS) + AW'(col_q));
	assign ent_addr  = AW'(AW'(q_entry.y) * AW'(COLS) + AW'(q_entry.x));
	assign slot_free = !out_valid_q || rsp.ready;
	assign q_ready   = (state_q == ST_IDLE) && slot_free;
	assign init_busy = init_q;

	// Sequencer: executes one command, walking the store for clear and scroll.
	always_comb begin
		state_d = state_q;
		row_d   = row_q;
		col_d   = col_q;
		color_d = color_q;
		esc_d   = esc_q;
		cnt_d   = cnt_q;
		tab_d   = tab_q;
		ch_d    = ch_q;
		ret_d   = ret_q;
		init_d  = init_q;
		pend_d  = 1'b0;
		fin     = 1'b0;
		fin_rd  = '0;
		fin_bad = 1'b0;
		we      = 1'b0;
		waddr   = cnt_q;
		wdata   = '0;
		raddr   = ent_addr;

		unique case (state_q)
			ST_CLR: begin
				we = 1'b1;
				if (cnt_q == AW'(CELLS - 1)) begin
					state_d = ST_IDLE;
					if (init_q) begin
						init_d = 1'b0;
					end else begin
						row_d = '0;
						col_d = '0;
						fin   = 1'b1;
					end
				end else begin
					cnt_d = cnt_q + AW'(1);
				end
			end
			ST_IDLE: begin
				if (q_valid && slot_free) begin
					case (q_entry.op)
						OP_PUT: begin
							if (esc_q) begin
								color_d = q_entry.ch;
								esc_d   = 1'b0;
								fin     = 1'b1;
							end else begin
								case (q_entry.ch)
									CH_NL: begin
										if (row_q >= RW'(ROWS - 1)) begin
											ret_d   = 1'b0;
											cnt_d   = '0;
											state_d = ST_SCR;
										end else begin
											row_d = row_q + RW'(1);
											col_d = '0;
											fin   = 1'b1;
										end
									end
									CH_TAB: begin
										ch_d    = CH_SPACE;
										tab_d   = TW'(TAB_WIDTH);
										state_d = ST_WCELL;
									end
									CH_ESC: begin
										esc_d = 1'b1;
										fin   = 1'b1;
									end
									CH_NUL: begin
										fin = 1'b1;
									end
									default: begin
										ch_d    = q_entry.ch;
										tab_d   = TW'(1);
										state_d = ST_WCELL;
									end
								endcase
							end
						end
						OP_CLEAR: begin
							cnt_d   = '0;
							state_d = ST_CLR;
						end
						OP_LEFT: begin
							if (!full && col_q != '0) begin
								col_d = col_q - CW'(1);
							end
							fin = 1'b1;
						end
						OP_RIGHT: begin
							if (!full && col_q != CW'(COLS - 1)) begin
								col_d = col_q + CW'(1);
							end
							fin = 1'b1;
						end
						OP_UP: begin
							if (full) begin
								row_d = RW'(ROWS - 1);
								col_d = '0;
							end else if (row_q != '0) begin
								row_d = row_q - RW'(1);
							end
							fin = 1'b1;
						end
						OP_DOWN: begin
							if (!full && row_q < RW'(ROWS - 1)) begin
								row_d = row_q + RW'(1);
							end
							fin = 1'b1;
						end
						OP_PLACE: begin
							if (q_entry.pos_ok) begin
								row_d = RW'(q_entry.y);
								col_d = CW'(q_entry.x);
							end
							fin_bad = !q_entry.pos_ok;
							fin     = 1'b1;
						end
						default: begin
							if (q_entry.pos_ok) begin
								state_d = ST_RDW;
							end else begin
								fin_bad = 1'b1;
								fin     = 1'b1;
							end
						end
					endcase
				end
			end
			ST_SCR: begin
				// Read a row below, write it back one row up on the next cycle.
				raddr  = AW'(cnt_q + AW'(COLS));
				pend_d = 1'b1;
				if (cnt_q == AW'(CELLS - COLS - 1)) begin
					cnt_d   = AW'(CELLS - COLS);
					state_d = ST_FILL;
				end else begin
					cnt_d = cnt_q + AW'(1);
				end
			end
			ST_FILL: begin
				if (!pend_s1) begin
					we    = 1'b1;
					wdata = BLANK_FILL;
					if (cnt_q == AW'(CELLS - 1)) begin
						row_d = RW'(ROWS - 1);
						col_d = '0;
						if (ret_q) begin
							state_d = ST_WCELL;
						end else begin
							state_d = ST_IDLE;
							fin     = 1'b1;
						end
					end else begin
						cnt_d = cnt_q + AW'(1);
					end
				end
			end
			ST_WCELL: begin
				if (full) begin
					ret_d   = 1'b1;
					cnt_d   = '0;
					state_d = ST_SCR;
				end else begin
					we    = 1'b1;
					waddr = cur_addr;
					wdata = {color_q, ch_q};
					if (col_q == CW'(COLS - 1)) begin
						col_d = '0;
						row_d = row_q + RW'(1);
					end else begin
						col_d = col_q + CW'(1);
					end
					tab_d = tab_q - TW'(1);
					if (tab_q == TW'(1)) begin
						state_d = ST_IDLE;
						fin     = 1'b1;
					end
				end
			end
			ST_RDW: begin
				fin_rd  = rdata;
				fin     = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// A pending copy write from the scroll walk takes the port first.
		if (pend_s1) begin
			we    = 1'b1;
			waddr = waddr_s1;
			wdata = rdata;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			row_q       <= '0;
			col_q       <= '0;
			color_q     <= RESET_COLOR;
			esc_q       <= 1'b0;
			cnt_q       <= '0;
			tab_q       <= '0;
			ret_q       <= 1'b0;
			init_q      <= 1'b1;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			row_q   <= row_d;
			col_q   <= col_d;
			color_q <= color_d;
			esc_q   <= esc_d;
			cnt_q   <= cnt_d;
			tab_q   <= tab_d;
			ret_q   <= ret_d;
			init_q  <= init_d;
			pend_s1 <= pend_d;
			if (fin) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		ch_q     <= ch_d;
		waddr_s1 <= cnt_q;
		if (fin) begin
			out_row_q   <= row_d;
			out_col_q   <= col_d;
			out_color_q <= color_d;
			out_rd_q    <= fin_rd;
			out_bad_q   <= fin_bad;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.cursor_row   = ROWO_W'(out_row_q);
	assign rsp.cursor_col   = COLX_W'(out_col_q);
	assign rsp.text_color   = out_color_q;
	assign rsp.read_data    = out_rd_q;
	assign rsp.bad_position = out_bad_q;

endmodule

### hw/rtl/text_console_writer_top.sv
`timescale 1ns / 1ps

// Channel   Role      Beat contents
// cmd       sink      op, char_byte, col_x, row_y
// rsp       source    cursor_row, cursor_col, text_color, read_data, bad_position
//
// Cursor moves, placement, colour and escape bytes finish straight from idle;
// a printable byte writes one cell, a tab writes TAB_WIDTH spaces, and a cell
// read waits for the registered RAM port. A newline on the last row scrolls,
// as does a cell write with the cursor past the end; clear walks every cell.
// After reset a clearing pass over all ROWS*COLS cells runs before cmd is ready.
// A two-beat queue lets cmd keep accepting while the executor or rsp stalls.
module text_console_writer_top #(
	parameter int COLS      = 80,
	parameter int ROWS      = 25,
	parameter int TAB_WIDTH = 4
) (
	input logic     clk,
	input logic     arst_n,
	ctw_cmd_if.sink cmd,
	ctw_rsp_if.source rsp
);
	import ctw_pkg::*;

	logic     q_valid;
	logic     q_ready;
	logic     init_busy;
	q_entry_t q_entry;

	// Front: accepts and classifies beats into a short queue.
	ctw_front #(.COLS(COLS), .ROWS(ROWS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.init_busy (init_busy),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_entry   (q_entry)
	);

	// Back: executes commands against the cell store.
	ctw_back #(.COLS(COLS), .ROWS(ROWS), .TAB_WIDTH(TAB_WIDTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_entry   (q_entry),
		.init_busy (init_busy),
		.rsp       (rsp)
	);

endmodule

### test/ctw_tb_ifs.sv
`timescale 1ns / 1ps

// The channel interfaces come with the RTL (ctw_cmd_if, ctw_rsp_if); this file
// holds the item types that the stimulus and expected-response queues carry.
package ctw_tb_pkg;
	import ctw_pkg::*;

	typedef struct packed {
		op_t               op;
		logic [BYTE_W-1:0] ch;
		logic [COLX_W-1:0] x;
		logic [ROWY_W-1:0] y;
	} cmd_beat_t;

	typedef struct packed {
		logic [ROWO_W-1:0] row;
		logic [COLX_W-1:0] col;
		logic [BYTE_W-1:0] color;
		logic [CELL_W-1:0] rd;
		logic              bad;
	} rsp_beat_t;
endpackage

### test/text_console_writer_top_tb.sv
`timescale 1ns / 1ps

module text_console_writer_top_tb;
	import ctw_pkg::*;
	import ctw_tb_pkg::*;

	localparam int COLS = 80;
	localparam int ROWS = 25;
	localparam int TAB_WIDTH = 4;
	localparam int CELLS = COLS * ROWS;
	localparam int CYCLE_LIMIT = 10000000;

	logic clk;
	logic arst_n;

	ctw_cmd_if cmd ();
	ctw_rsp_if rsp ();

	text_console_writer_top #(.COLS(COLS), .ROWS(ROWS), .TAB_WIDTH(TAB_WIDTH)) uut (
		.clk(clk), .arst_n(arst_n), .cmd(cmd.sink), .rsp(rsp.source)
	);

	// Console shadow used to predict each response beat.
	logic [CELL_W-1:0] shadow_cells [CELLS];
	int unsigned shadow_cursor;
	logic [BYTE_W-1:0] shadow_color;
	bit shadow_esc;

	cmd_beat_t pending_cmds [$];
	rsp_beat_t expected_rsps [$];
	int errors;
	int cycles;
	bit stim_done;
	bit quiet;
	bit hold_sender;
	bit cmd_taken;
	int src_gap;
	int snk_gap;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %0h want %0h", what, got, want);
		errors++;
	endtask

	function automatic void scroll_shadow();
		for (int i = 0; i < CELLS - COLS; i++) shadow_cells[i] = shadow_cells[i + COLS];
		for (int i = CELLS - COLS; i < CELLS; i++) shadow_cells[i] = BLANK_FILL;
		shadow_cursor = CELLS - COLS;
	endfunction

	function automatic void write_shadow(input logic [BYTE_W-1:0] c);
		if (shadow_cursor >= CELLS) scroll_shadow();
		shadow_cells[shadow_cursor] = {shadow_color, c};
		shadow_cursor++;
	endfunction

	// Apply one command beat to the shadow and return the response it yields.
	function automatic rsp_beat_t console_step(input cmd_beat_t c);
		rsp_beat_t r;
		bit full;
		bit pos_ok;
		r = '0;
		full = shadow_cursor >= CELLS;
		pos_ok = (c.x < COLS) && (c.y < ROWS);
		case (c.op)
			OP_PUT: begin
				if (shadow_esc) begin
					shadow_color = c.ch;
					shadow_esc = 0;
				end else if (c.ch == CH_NL) begin
					if (shadow_cursor / COLS >= ROWS - 1) scroll_shadow();
					else shadow_cursor = (shadow_cursor / COLS + 1) * COLS;
				end else if (c.ch == CH_TAB) begin
					for (int k = 0; k < TAB_WIDTH; k++) write_shadow(CH_SPACE);
				end else if (c.ch == CH_ESC) begin
					shadow_esc = 1;
				end else if (c.ch != CH_NUL) begin
					write_shadow(c.ch);
				end
			end
			OP_CLEAR: begin
				for (int i = 0; i < CELLS; i++) shadow_cells[i] = '0;
				shadow_cursor = 0;
			end
			OP_LEFT: if (!full && shadow_cursor % COLS != 0) shadow_cursor--;
			OP_RIGHT: if (!full && shadow_cursor % COLS != COLS - 1) shadow_cursor++;
			OP_UP: begin
				if (full) shadow_cursor = CELLS - COLS;
				else if (shadow_cursor / COLS != 0) shadow_cursor -= COLS;
			end
			OP_DOWN: if (!full && shadow_cursor / COLS < ROWS - 1) shadow_cursor += COLS;
			OP_PLACE: begin
				if (pos_ok) shadow_cursor = c.y * COLS + c.x;
				else r.bad = 1;
			end
			default: begin
				if (pos_ok) r.rd = shadow_cells[c.y * COLS + c.x];
				else r.bad = 1;
			end
		endcase
		r.row = ROWO_W'(shadow_cursor / COLS);
		r.col = COLX_W'(shadow_cursor % COLS);
		r.color = shadow_color;
		return r;
	endfunction

	function automatic cmd_beat_t mk(input op_t op, input int ch, input int x, input int y);
		cmd_beat_t c;
		c.op = op;
		c.ch = BYTE_W'(ch);
		c.x = COLX_W'(x);
		c.y = ROWY_W'(y);
		return c;
	endfunction

	// Random beat: mostly printable bytes; control bytes, moves, place, read, clear.
	function automatic cmd_beat_t random_beat();
		int sel;
		int ch;
		sel = $urandom_range(0, 99);
		if (sel < 55) ch = $urandom_range(32, 255);
		else if (sel < 62) ch = CH_NL;
		else if (sel < 66) ch = CH_TAB;
		else if (sel < 70) ch = CH_ESC;
		else if (sel < 72) ch = CH_NUL;
		else ch = -1;
		if (ch >= 0)
			return mk(OP_PUT, ch, $urandom_range(0, 127), $urandom_range(0, 31));
		sel = $urandom_range(0, 99);
		if (sel < 2) return mk(OP_CLEAR, $urandom, $urandom, $urandom);
		if (sel < 50) return mk(op_t'($urandom_range(OP_LEFT, OP_DOWN)), $urandom,
			$urandom, $urandom);
		if (sel < 90)
			return mk(($urandom_range(0, 1) ? OP_PLACE : OP_READ), $urandom,
				$urandom_range(0, COLS - 1), $urandom_range(0, ROWS - 1));
		return mk(($urandom_range(0, 1) ? OP_PLACE : OP_READ), $urandom,
			$urandom_range(0, 127), $urandom_range(0, 31));
	endfunction

	// Clock.
	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// Reset, inputs at known values, and the stimulus queue.
	initial begin
		arst_n = 0;
		cmd.valid = 0;
		cmd.op = '0;
		cmd.char_byte = '0;
		cmd.col_x = '0;
		cmd.row_y = '0;
		rsp.ready = 0;
		errors = 0;
		stim_done = 0;
		quiet = 0;
		hold_sender = 0;
		cmd_taken = 0;
		shadow_cursor = 0;
		shadow_color = RESET_COLOR;
		shadow_esc = 0;
		for (int i = 0; i < CELLS; i++) shadow_cells[i] = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed part: reads of unwritten cells, edges, control bytes, bad positions.
		pending_cmds.push_back(mk(OP_READ, 0, 0, 0));
		pending_cmds.push_back(mk(OP_LEFT, 0, 0, 0));
		pending_cmds.push_back(mk(OP_UP, 0, 0, 0));
		pending_cmds.push_back(mk(OP_PUT, 8'hff, 0, 0));
		pending_cmds.push_back(mk(OP_PUT, CH_NUL, 0, 0));
		pending_cmds.push_back(mk(OP_PUT, CH_TAB, 0, 0));
		pending_cmds.push_back(mk(OP_PUT, CH_ESC, 0, 0));
		pending_cmds.push_back(mk(OP_PUT, CH_NUL, 0, 0));
		pending_cmds.push_back(mk(OP_PUT, CH_ESC, 0, 0));
		pending_cmds.push_back(mk(OP_PUT, 8'hff, 0, 0));
		pending_cmds.push_back(mk(OP_PUT, 8'h41, 0, 0));
		pending_cmds.push_back(mk(OP_READ, 0, 1, 0));
		pending_cmds.push_back(mk(OP_PLACE, 0, 79, 24));
		pending_cmds.push_back(mk(OP_RIGHT, 0, 0, 0));
		pending_cmds.push_back(mk(OP_DOWN, 0, 0, 0));
		pending_cmds.push_back(mk(OP_PUT, 8'h5a, 0, 0));
		pending_cmds.push_back(mk(OP_RIGHT, 0, 0, 0));
		pending_cmds.push_back(mk(OP_UP, 0, 0, 0));
		pending_cmds.push_back(mk(OP_PUT, CH_NL, 0, 0));
		pending_cmds.push_back(mk(OP_PLACE, 0, 127, 31));
		pending_cmds.push_back(mk(OP_READ, 0, 80, 0));
		pending_cmds.push_back(mk(OP_READ, 0, 0, 25));
		pending_cmds.push_back(mk(OP_READ, 0, 79, 24));
		pending_cmds.push_back(mk(OP_CLEAR, 0, 0, 0));
		pending_cmds.push_back(mk(OP_READ, 0, 0, 0));
		wait (pending_cmds.size() == 0 && !cmd.valid);

		// Let the console drain completely before the random traffic.
		hold_sender = 1;
		wait (expected_rsps.size() == 0);
		@(negedge clk);
		hold_sender = 0;

		for (int n = 0; n < 800; n++) begin
			if (n == 700) begin
				wait (pending_cmds.size() == 0);
				quiet = 1;
			end
			pending_cmds.push_back(random_beat());
			if (pending_cmds.size() > 4) wait (pending_cmds.size() <= 2);
		end
		wait (pending_cmds.size() == 0 && !cmd.valid);
		stim_done = 1;
	end

	// Sender: offers queued beats, drives rsp.ready; inputs change on the falling edge.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!cmd.valid || cmd_taken) begin
				if (src_gap > 0) begin
					src_gap <= src_gap - 1;
					cmd.valid <= 0;
				end else if (!hold_sender && pending_cmds.size() > 0) begin
					cmd_beat_t c;
					c = pending_cmds.pop_front();
					cmd.valid <= 1;
					cmd.op <= c.op;
					cmd.char_byte <= c.ch;
					cmd.col_x <= c.x;
					cmd.row_y <= c.y;
					if (!quiet && $urandom_range(0, 9) == 0) src_gap <= $urandom_range(1, 11);
				end else begin
					cmd.valid <= 0;
				end
			end
			if (snk_gap > 0) begin
				snk_gap <= snk_gap - 1;
				rsp.ready <= 0;
			end else if (!quiet && $urandom_range(0, 11) == 0) begin
				snk_gap <= $urandom_range(0, 10);
				rsp.ready <= 0;
			end else begin
				rsp.ready <= 1;
			end
		end else begin
			src_gap <= 0;
			snk_gap <= 0;
		end
	end

	// Monitor: predicts accepted commands and checks responses at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			cmd_taken = cmd.valid && cmd.ready;
			if (cmd.valid && cmd.ready)
				expected_rsps.push_back(console_step(mk(op_t'(cmd.op), cmd.char_byte,
					cmd.col_x, cmd.row_y)));
			if (rsp.valid && rsp.ready) begin
				if (expected_rsps.size() == 0) begin
					report("unexpected beat", 0, 0);
				end else begin
					rsp_beat_t w;
					w = expected_rsps.pop_front();
					if (rsp.cursor_row !== w.row) report("cursor_row", rsp.cursor_row, w.row);
					if (rsp.cursor_col !== w.col) report("cursor_col", rsp.cursor_col, w.col);
					if (rsp.text_color !== w.color) report("text_color", rsp.text_color, w.color);
					if (rsp.read_data !== w.rd) report("read_data", rsp.read_data, w.rd);
					if (rsp.bad_position !== w.bad) report("bad_position", rsp.bad_position, w.bad);
				end
			end
		end
	end

	// End of run and watchdog.
	initial begin
		cycles = 0;
		fork
			begin
				wait (stim_done && expected_rsps.size() == 0);
				repeat (4 * CELLS + 50) @(posedge clk);
			end
			begin
				while (cycles < CYCLE_LIMIT) begin
					@(posedge clk);
					cycles++;
				end
				errors++;
				$display("timeout");
			end
		join_any
		if (errors == 0)
			$display("text_console_writer_top_tb OK");
		else
			$display("text_console_writer_top_tb NOT OK");
		$finish;
	end

endmodule
